>>> rtl/gn3_pkg.sv
// Shared constants, types and permutation table for the 3D gradient noise block.
`timescale 1ns / 1ps
package gn3_pkg;
    localparam int COORD_W       = 32;
    localparam int NOISE_W       = 18;
    localparam int PERM_SIZE_DEF = 256;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ROM_AW        = 8;
    localparam int NSTG          = 12;
    localparam int OUT_MAX       = 131071;
    localparam int OUT_MIN       = -131072;

    typedef logic [NSTG-1:0] t_stage_en;
    typedef logic [ROM_AW-1:0] t_rom_addr;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
        8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
        8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
        8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
        8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
        8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
        8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
        8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
        8'd215,8'd61,8'd156,8'd180
    };

    function automatic t_rom_addr perm(input t_rom_addr i);
        return PERM_ROM[i];
    endfunction
endpackage

>>> rtl/gn3_if.sv
// Request channels: coordinate input and noise output.
`timescale 1ns / 1ps
interface gn3_coord_if;
    import gn3_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    modport source(output valid, coord_x, coord_y, coord_z, input ready);
    modport sink(input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface gn3_noise_if;
    import gn3_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [NOISE_W-1:0] noise_value;
    modport source(output valid, noise_value, input ready);
    modport sink(input valid, noise_value, output ready);
endinterface

>>> rtl/gradient_noise_3d.sv
// Top level of the pipelined 3D improved gradient noise generator.
// Usage:
//   i_coord carries one point per request (coord_x/y/z, signed fixed point
//   with FRAC_BITS fraction bits); o_noise returns one noise_value per point,
//   in order, signed with FRAC_BITS fraction bits, saturated to 18 bits.
//   Throughput is one point per clock while the receiver does not stall.
//   The pipeline holds an input register, three permutation table lookup
//   stages, a gradient stage, a fade/align stage, then three blend levels
//   of a multiply stage and an add stage each.
//   Each stage has its own valid bit; a stage advances when it is empty or
//   the one after it advances, so bubbles close up while o_noise is stalled
//   and i_coord.ready drops only once every stage holds a point.
//   Synchronous reset (i_rst_n low) empties all stages; no state is kept.
`timescale 1ns / 1ps
module gradient_noise_3d #(
    parameter int PERM_SIZE = gn3_pkg::PERM_SIZE_DEF,
    parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gn3_coord_if.sink      i_coord,
    gn3_noise_if.source    o_noise
);
    import gn3_pkg::*;

    localparam int VW = (FRAC_BITS + 6 > NOISE_W + 1) ? FRAC_BITS + 6 : NOISE_W + 1;
    localparam logic [7:0] PMASK = 8'(PERM_SIZE - 1);
    localparam logic signed [VW-1:0] SAT_HI = VW'(OUT_MAX);
    localparam logic signed [VW-1:0] SAT_LO = VW'(OUT_MIN);

    t_stage_en            en;
    t_stage_en            r_vld;
    logic [7:0]           r_cell [3];
    logic [FRAC_BITS-1:0] r_frac [3];
    logic signed [VW-1:0] grad [8];
    logic signed [VW-1:0] wgt  [3];
    logic signed [VW-1:0] r_wy [2];
    logic signed [VW-1:0] r_wz [4];
    logic signed [VW-1:0] xa [4], xb [4], xr [4];
    logic signed [VW-1:0] ya [2], yb [2], yr [2];
    logic signed [VW-1:0] za [1], zb [1], zr [1];

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || o_noise.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) r_vld[k] <= (k == 0) ? i_coord.valid : r_vld[(k == 0) ? 0 : k-1];
            end
        end
    end

    // Floor keeps the integer bits; only the low table address bits matter.
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_cell[0] <= i_coord.coord_x[FRAC_BITS+7:FRAC_BITS] & PMASK;
            r_cell[1] <= i_coord.coord_y[FRAC_BITS+7:FRAC_BITS] & PMASK;
            r_cell[2] <= i_coord.coord_z[FRAC_BITS+7:FRAC_BITS] & PMASK;
            r_frac[0] <= i_coord.coord_x[FRAC_BITS-1:0];
            r_frac[1] <= i_coord.coord_y[FRAC_BITS-1:0];
            r_frac[2] <= i_coord.coord_z[FRAC_BITS-1:0];
        end
        if (en[6]) begin
            r_wy[0] <= wgt[1];
            r_wz[0] <= wgt[2];
        end
        if (en[7]) begin
            r_wy[1] <= r_wy[0];
            r_wz[1] <= r_wz[0];
        end
        if (en[8]) r_wz[2] <= r_wz[1];
        if (en[9]) r_wz[3] <= r_wz[2];
    end

    gn3_hash #(.FRAC_BITS(FRAC_BITS), .VW(VW)) u_hash (
        .i_clk  (i_clk),
        .i_en   (en[5:1]),
        .i_cell (r_cell),
        .i_frac (r_frac),
        .o_grad (grad)
    );

    gn3_fade #(.FRAC_BITS(FRAC_BITS), .VW(VW)) u_fade (
        .i_clk (i_clk),
        .i_en  (en[5:1]),
        .i_t   (r_frac),
        .o_w   (wgt)
    );

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            xa[k] = grad[2*k];
            xb[k] = grad[2*k+1];
        end
        for (int k = 0; k < 2; k++) begin
            ya[k] = xr[2*k];
            yb[k] = xr[2*k+1];
        end
        za[0] = yr[0];
        zb[0] = yr[1];
    end

    gn3_lerp #(.FRAC_BITS(FRAC_BITS), .VW(VW), .LANES(4)) u_lerp_x (
        .i_clk (i_clk), .i_en (en[7:6]), .i_w (wgt[0]), .i_a (xa), .i_b (xb), .o_y (xr)
    );

    gn3_lerp #(.FRAC_BITS(FRAC_BITS), .VW(VW), .LANES(2)) u_lerp_y (
        .i_clk (i_clk), .i_en (en[9:8]), .i_w (r_wy[1]), .i_a (ya), .i_b (yb), .o_y (yr)
    );

    gn3_lerp #(.FRAC_BITS(FRAC_BITS), .VW(VW), .LANES(1)) u_lerp_z (
        .i_clk (i_clk), .i_en (en[11:10]), .i_w (r_wz[3]), .i_a (za), .i_b (zb), .o_y (zr)
    );

    always_comb begin
        if (zr[0] > SAT_HI) begin
            o_noise.noise_value = NOISE_W'(SAT_HI);
        end else if (zr[0] < SAT_LO) begin
            o_noise.noise_value = NOISE_W'(SAT_LO);
        end else begin
            o_noise.noise_value = NOISE_W'(zr[0]);
        end
    end

    assign o_noise.valid = r_vld[NSTG-1];
    assign i_coord.ready = en[0];
endmodule

>>> rtl/gn3_hash.sv
// Corner hashing through the permutation table and gradient dot products.
`timescale 1ns / 1ps
module gn3_hash #(
    parameter int FRAC_BITS = 16,
    parameter int VW        = 22
) (
    input  logic                 i_clk,
    input  logic [4:0]           i_en,
    input  logic [7:0]           i_cell [3],
    input  logic [FRAC_BITS-1:0] i_frac [3],
    output logic signed [VW-1:0] o_grad [8]
);
    import gn3_pkg::*;

    localparam logic signed [VW-1:0] ONE = VW'(1) <<< FRAC_BITS;

    logic [7:0]           r_px [2];
    logic [7:0]           r_c1 [2];
    logic [7:0]           r_c2;
    logic [7:0]           r_a  [4];
    logic [3:0]           r_h  [8];
    logic [FRAC_BITS-1:0] r_f1 [3];
    logic [FRAC_BITS-1:0] r_f2 [3];
    logic [FRAC_BITS-1:0] r_f3 [3];
    logic signed [VW-1:0] r_g4 [8];
    logic signed [VW-1:0] r_g5 [8];
    logic signed [VW-1:0] n_g  [8];

    always_comb begin
        logic signed [VW-1:0] d [3][2];
        logic signed [VW-1:0] u, v, dx, dy, dz;
        for (int k = 0; k < 3; k++) begin
            d[k][0] = $signed(VW'(r_f3[k]));
            d[k][1] = d[k][0] - ONE;
        end
        for (int c = 0; c < 8; c++) begin
            dx = d[0][c & 1];
            dy = d[1][(c >> 1) & 1];
            dz = d[2][(c >> 2) & 1];
            u = (r_h[c] inside {[4'd0:4'd7], 4'd12, 4'd13}) ? dx : dy;
            v = (r_h[c] inside {[4'd0:4'd3], 4'd12, 4'd13}) ? dy : dz;
            if (r_h[c][0]) u = -u;
            if (r_h[c][1]) v = -v;
            n_g[c] = u + v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_px[0] <= perm(i_cell[0]);
            r_px[1] <= perm(i_cell[0] + 8'd1);
            r_c1[0] <= i_cell[1];
            r_c1[1] <= i_cell[2];
            r_f1    <= i_frac;
        end
        if (i_en[1]) begin
            for (int j = 0; j < 4; j++) begin
                r_a[j] <= perm(r_px[j & 1] + r_c1[0] + 8'((j >> 1) & 1));
            end
            r_c2 <= r_c1[1];
            r_f2 <= r_f1;
        end
        if (i_en[2]) begin
            for (int c = 0; c < 8; c++) begin
                r_h[c] <= 4'(perm(r_a[c & 3] + r_c2 + 8'((c >> 2) & 1)));
            end
            r_f3 <= r_f2;
        end
        if (i_en[3]) r_g4 <= n_g;
        if (i_en[4]) r_g5 <= r_g4;
    end

    assign o_grad = r_g5;
endmodule

>>> rtl/gn3_fade.sv
// Quintic fade curve 6t^5-15t^4+10t^3, one power per stage.
`timescale 1ns / 1ps
module gn3_fade #(
    parameter int FRAC_BITS = 16,
    parameter int VW        = 22
) (
    input  logic                 i_clk,
    input  logic [4:0]           i_en,
    input  logic [FRAC_BITS-1:0] i_t [3],
    output logic signed [VW-1:0] o_w [3]
);
    import gn3_pkg::*;

    logic [FRAC_BITS-1:0] r_t1 [3], r_t2 [3], r_t3 [3];
    logic [FRAC_BITS-1:0] r_p2 [3], r_p3 [3], r_p3b [3], r_p3c [3];
    logic [FRAC_BITS-1:0] r_p4 [3], r_p4b [3], r_p5 [3];
    logic signed [VW-1:0] r_w  [3];

    function automatic logic [FRAC_BITS-1:0] mulf(input logic [FRAC_BITS-1:0] a,
                                                  input logic [FRAC_BITS-1:0] b);
        logic [2*FRAC_BITS-1:0] p;
        p = a * b;
        return p[2*FRAC_BITS-1:FRAC_BITS];
    endfunction

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_en[0]) begin
                r_t1[k] <= i_t[k];
                r_p2[k] <= mulf(i_t[k], i_t[k]);
            end
            if (i_en[1]) begin
                r_t2[k] <= r_t1[k];
                r_p3[k] <= mulf(r_p2[k], r_t1[k]);
            end
            if (i_en[2]) begin
                r_t3[k]  <= r_t2[k];
                r_p3b[k] <= r_p3[k];
                r_p4[k]  <= mulf(r_p3[k], r_t2[k]);
            end
            if (i_en[3]) begin
                r_p3c[k] <= r_p3b[k];
                r_p4b[k] <= r_p4[k];
                r_p5[k]  <= mulf(r_p4[k], r_t3[k]);
            end
            if (i_en[4]) begin
                r_w[k] <= VW'($signed(VW'(r_p5[k])) * 6)
                        - VW'($signed(VW'(r_p4b[k])) * 15)
                        + VW'($signed(VW'(r_p3c[k])) * 10);
            end
        end
    end

    assign o_w = r_w;
endmodule

>>> rtl/gn3_lerp.sv
// Lanes of linear blends: registered product, then registered sum.
`timescale 1ns / 1ps
module gn3_lerp #(
    parameter int FRAC_BITS = 16,
    parameter int VW        = 22,
    parameter int LANES     = 4
) (
    input  logic                 i_clk,
    input  logic [1:0]           i_en,
    input  logic signed [VW-1:0] i_w,
    input  logic signed [VW-1:0] i_a [LANES],
    input  logic signed [VW-1:0] i_b [LANES],
    output logic signed [VW-1:0] o_y [LANES]
);
    import gn3_pkg::*;

    logic signed [2*VW:0] r_p [LANES];
    logic signed [VW-1:0] r_a [LANES];
    logic signed [VW-1:0] r_y [LANES];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANES; k++) begin
            if (i_en[0]) begin
                r_p[k] <= (2*VW+1)'(i_w) * ((2*VW+1)'(i_b[k]) - (2*VW+1)'(i_a[k]));
                r_a[k] <= i_a[k];
            end
            if (i_en[1]) begin
                r_y[k] <= r_a[k] + VW'(r_p[k] >>> FRAC_BITS);
            end
        end
    end

    assign o_y = r_y;
endmodule

>>> rtl/gn3_checker.sv
// Port-level checker for the gradient noise block, with its bind.
`timescale 1ns / 1ps
module gn3_port_props (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // With no result waiting the pipeline cannot be full.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // Input may block only while the output is stalled.
    a_block_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input blocked without output stall");
endmodule

bind gradient_noise_3d gn3_port_props u_gn3_port_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_coord.valid),
    .i_in_ready  (i_coord.ready),
    .i_out_valid (o_noise.valid),
    .i_out_ready (o_noise.ready)
);

>>> tb/gn3_checker.sv
// Checker for the 3D gradient noise block: predicts each noise value and compares.
`timescale 1ns / 1ps
module gn3_checker #(
    parameter int PERM_SIZE = gn3_pkg::PERM_SIZE_DEF,
    parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gn3_coord_if.sink   i_coord,
    gn3_noise_if.sink   i_noise,
    output int          o_fail_cnt,
    output int          o_pending
);
    import gn3_pkg::*;

    logic signed [NOISE_W-1:0] noise_q[$];

    assign o_pending = noise_q.size();

    function automatic longint floor_sh(input longint v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic longint grad_dot(input int unsigned x, input int unsigned y,
                                        input int unsigned z, input longint dx,
                                        input longint dy, input longint dz);
        int unsigned h;
        longint u;
        longint v;
        h = PERM_ROM[(PERM_ROM[(PERM_ROM[x & 255] + y) & 255] + z) & 255] & 15;
        u = (h < 8 || h == 12 || h == 13) ? dx : dy;
        v = (h < 4 || h == 12 || h == 13) ? dy : dz;
        if (h[0]) u = -u;
        if (h[1]) v = -v;
        return u + v;
    endfunction

    function automatic longint fade_w(input longint t);
        longint t2;
        longint t3;
        longint t4;
        longint t5;
        t2 = floor_sh(t * t);
        t3 = floor_sh(t2 * t);
        t4 = floor_sh(t3 * t);
        t5 = floor_sh(t4 * t);
        return 6 * t5 - 15 * t4 + 10 * t3;
    endfunction

    function automatic longint mix(input longint w, input longint a, input longint b);
        return a + floor_sh(w * (b - a));
    endfunction

    function automatic logic signed [NOISE_W-1:0] noise_of(input logic signed [31:0] cx,
                                                           input logic signed [31:0] cy,
                                                           input logic signed [31:0] cz);
        int unsigned ix;
        int unsigned iy;
        int unsigned iz;
        longint dx;
        longint dy;
        longint dz;
        longint one;
        longint wx;
        longint wy;
        longint wz;
        longint c[8];
        longint y0;
        longint y1;
        longint r;
        one = longint'(1) << FRAC_BITS;
        ix = int'(floor_sh(longint'(cx))) & (PERM_SIZE - 1);
        iy = int'(floor_sh(longint'(cy))) & (PERM_SIZE - 1);
        iz = int'(floor_sh(longint'(cz))) & (PERM_SIZE - 1);
        dx = longint'({1'b0, cx}) & (one - 1);
        dy = longint'({1'b0, cy}) & (one - 1);
        dz = longint'({1'b0, cz}) & (one - 1);
        for (int k = 0; k < 8; k++) begin
            c[k] = grad_dot(ix + k[0], iy + k[1], iz + k[2],
                            dx - (k[0] ? one : 0), dy - (k[1] ? one : 0),
                            dz - (k[2] ? one : 0));
        end
        wx = fade_w(dx);
        wy = fade_w(dy);
        wz = fade_w(dz);
        y0 = mix(wy, mix(wx, c[0], c[1]), mix(wx, c[2], c[3]));
        y1 = mix(wy, mix(wx, c[4], c[5]), mix(wx, c[6], c[7]));
        r = mix(wz, y0, y1);
        if (r > OUT_MAX) r = OUT_MAX;
        if (r < OUT_MIN) r = OUT_MIN;
        return r[NOISE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_fail_cnt <= 0;
        end else begin
            if (i_coord.valid && i_coord.ready)
                noise_q.insert(noise_q.size(),
                               noise_of(i_coord.coord_x, i_coord.coord_y, i_coord.coord_z));
            if (i_noise.valid && i_noise.ready) begin
                if (noise_q.size() == 0) begin
                    $error("noise_value: unexpected result %0d", i_noise.noise_value);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else if (noise_q[0] !== i_noise.noise_value) begin
                    $error("noise_value: expected %0d actual %0d", noise_q[0],
                           i_noise.noise_value);
                    o_fail_cnt <= o_fail_cnt + 1;
                    void'(noise_q.pop_front());
                end else begin
                    void'(noise_q.pop_front());
                end
            end
        end
    end
endmodule

>>> tb/gradient_noise_3d_tb.sv
// Top of the 3D gradient noise testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module gradient_noise_3d_tb;
    import gn3_pkg::*;

    localparam int N_RAND = 1450;

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt;
    int   pending;
    logic drain_on;

    gn3_coord_if coord_ch();
    gn3_noise_if noise_ch();

    gradient_noise_3d dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_coord(coord_ch),
                           .o_noise(noise_ch));
    gn3_checker chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_coord(coord_ch),
                     .i_noise(noise_ch), .o_fail_cnt(fail_cnt), .o_pending(pending));

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: hold ready low for a random stretch after each taken result, except while draining.
    initial begin
        int gap;
        noise_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = drain_on ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                noise_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            noise_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!noise_ch.valid);
            @(negedge i_clk);
        end
    end

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            coord_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        coord_ch.valid   <= 1'b1;
        coord_ch.coord_x <= x;
        coord_ch.coord_y <= y;
        coord_ch.coord_z <= z;
        do @(posedge i_clk); while (!coord_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
            2: return {16'($urandom_range(0, 3) - 1), 16'($urandom())};
            default: return {$urandom_range(0, 1) ? 16'h7fff : 16'h8000, 16'($urandom())};
        endcase
    endfunction

    initial begin
        logic [31:0] edge_v[8];
        bit burst;
        edge_v = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                   32'h0000ffff, 32'h00010000, 32'h00008000, 32'h00ff7fff};
        drain_on = 1'b0;
        coord_ch.valid = 1'b0;
        coord_ch.coord_x = '0;
        coord_ch.coord_y = '0;
        coord_ch.coord_z = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int k = 0; k < 24; k++)
            send_point(edge_v[k % 8], edge_v[(k / 3) % 8], edge_v[(k * 5 + 1) % 8], 1'b0);
        coord_ch.valid <= 1'b0;
        // Hold off until the pipe has emptied.
        do @(negedge i_clk); while (pending != 0);
        burst = 1'b0;
        for (int k = 0; k < N_RAND; k++) begin
            if (k % 100 == 0) burst = ($urandom_range(0, 3) == 0);
            send_point(rand_coord(), rand_coord(), rand_coord(), burst);
        end
        coord_ch.valid <= 1'b0;
        drain_on = 1'b1;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_cnt == 0) begin
            $display("gradient_noise_3d_tb OK");
        end else begin
            $display("gradient_noise_3d_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("gradient_noise_3d_tb NOT OK");
        $finish;
    end
endmodule

>>> files.f
rtl/gn3_pkg.sv
rtl/gn3_if.sv
rtl/gn3_hash.sv
rtl/gn3_fade.sv
rtl/gn3_lerp.sv
rtl/gradient_noise_3d.sv
rtl/gn3_checker.sv
tb/gn3_checker.sv
tb/gradient_noise_3d_tb.sv
